/* rtl/sha256_hash_engine_core_assert.svh */
// ----------------------------------------------------------------------------
// SHA-256 engine assertion macros
// Clocked, reset-gated property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SHA256_HASH_ENGINE_CORE_ASSERT_SVH
`define SHA256_HASH_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SHA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sha256he_pkg.sv */
// ----------------------------------------------------------------------------
// sha256he_pkg
// Shared types and constants of the SHA-256 engine.
// ----------------------------------------------------------------------------
package sha256he_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned HASH_WORDS  = 8;
    localparam int unsigned ROUNDS      = 64;

    // Word slots of the 64-bit length field inside the final block
    localparam logic [3:0] LEN_HI_SLOT = 4'd14;
    localparam logic [3:0] LAST_SLOT   = 4'd15;
    localparam logic [2:0] LAST_INDEX  = 3'd7;

    localparam logic [WORD_W-1:0] PAD_MARK_WORD = 32'h8000_0000;

    localparam logic [WORD_W-1:0] INIT_HASH [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_COMP,
        ST_OUT
    } eng_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ROUND,
        CS_ADD
    } cmp_state_t;

    // Commands from the sequencer to the compression unit
    typedef struct packed {
        logic              wr_en;
        logic [WORD_W-1:0] wr_data;
        logic              start;
        logic              chain_init;
        logic [2:0]        rd_idx;
    } cmp_ctrl_t;

    // Status back from the compression unit
    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] rd_data;
    } cmp_stat_t;

endpackage

/* rtl/sha256he_compress.sv */
// ----------------------------------------------------------------------------
// sha256he_compress
// Message schedule shift line, one compression round per cycle, chain value.
// ----------------------------------------------------------------------------
module sha256he_compress (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha256he_pkg::cmp_ctrl_t ctrl,
    output sha256he_pkg::cmp_stat_t stat
);
    import sha256he_pkg::*;

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    cmp_state_t        state_reg;
    cmp_state_t        state_next;
    logic [5:0]        round_reg;
    logic [WORD_W-1:0] var_reg   [HASH_WORDS];
    logic [WORD_W-1:0] sched_reg [BLOCK_WORDS];
    logic [WORD_W-1:0] chain_reg [HASH_WORDS];

    logic [WORD_W-1:0] t1;
    logic [WORD_W-1:0] t2;
    logic [WORD_W-1:0] ch;
    logic [WORD_W-1:0] mj;
    logic [WORD_W-1:0] sched_new;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = CS_ROUND;
                end
            end
            CS_ROUND:
            begin
                if (round_reg == 6'(ROUNDS - 1))
                begin
                    state_next = CS_ADD;
                end
            end
            CS_ADD:
            begin
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        stat.done    = (state_reg == CS_ADD);
        stat.rd_data = chain_reg[ctrl.rd_idx];
    end

    // Round and schedule datapath; sched_reg[0] always holds W[t]
    always_comb
    begin
        ch = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        mj = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2]) ^ (var_reg[1] & var_reg[2]);
        t1 = var_reg[7] + big_sigma1(var_reg[4]) + ch + ROUND_K[round_reg] + sched_reg[0];
        t2 = big_sigma0(var_reg[0]) + mj;
        sched_new = small_sigma1(sched_reg[14]) + sched_reg[9]
                  + small_sigma0(sched_reg[1]) + sched_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == CS_ROUND)
            begin
                round_reg <= round_reg + 6'd1;
            end
            else
            begin
                round_reg <= '0;
            end
        end
    end

    // Working variables: load from chain on start, advance one round a cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == CS_IDLE && ctrl.start)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                var_reg[i] <= chain_reg[i];
            end
        end
        else if (state_reg == CS_ROUND)
        begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
    end

    // Schedule shift line: message words shift in while loading,
    // expanded words shift in during rounds
    always_ff @(posedge clk)
    begin
        priority if (ctrl.wr_en)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[BLOCK_WORDS-1] <= ctrl.wr_data;
        end
        else if (state_reg == CS_ROUND)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[BLOCK_WORDS-1] <= sched_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                chain_reg[i] <= INIT_HASH[i];
            end
        end
        else
        begin
            priority if (ctrl.chain_init)
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    chain_reg[i] <= INIT_HASH[i];
                end
            end
            else if (state_reg == CS_ADD)
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + var_reg[i];
                end
            end
        end
    end

endmodule

/* rtl/sha256_hash_engine_core.sv */
// ----------------------------------------------------------------------------
// sha256_hash_engine_core
// Streaming SHA-256: packs message bytes into blocks, pads, emits the digest.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall | data_word, valid_bytes, end_of_message
//  out     | out_valid/out_stall | digest_word, word_index, last_word
//
//  An item that neither closes a block nor ends a message leaves in_stall low.
//  An item that closes a 16-word block holds in_stall while the 64 rounds
//  of the shared round unit run and their result is added into the chain value.
//  An ending item is also followed by the padding words (up to 18), one or two
//  compressions, then eight digest items, one per cycle unless out_stall holds.
//  rst_n clears all control state and loads the initial hash values.
//  in_stall stays high from the acceptance of a block-closing or ending item
//  until the block is idle again; out_stall only holds the current digest item.
//
module sha256_hash_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha256he_pkg::*;

    eng_state_t        state_reg;
    eng_state_t        state_next;

    // Partial word, left aligned: valid bytes at the top, zeros below
    logic [WORD_W-1:0] pend_reg;
    logic [WORD_W-1:0] pend_next;
    logic [1:0]        pend_cnt_reg;
    logic [1:0]        pend_cnt_next;
    logic [3:0]        word_cnt_reg;
    logic [3:0]        word_cnt_next;
    logic [63:0]       bit_cnt_reg;
    logic [63:0]       bit_cnt_next;
    logic              eom_reg;
    logic              eom_next;
    // Padding progress: mark word written, high length word written, all done
    logic              mark_done_reg;
    logic              mark_done_next;
    logic              len_hi_done_reg;
    logic              len_hi_done_next;
    logic              msg_done_reg;
    logic              msg_done_next;
    logic [2:0]        idx_reg;
    logic [2:0]        idx_next;

    logic              in_acc;
    logic              out_acc;
    logic [2:0]        n_bytes;
    logic [2:0]        total;
    logic [WORD_W-1:0] byte_mask;
    logic [63:0]       combined;
    logic [WORD_W-1:0] fill_word;
    logic              block_full;

    cmp_ctrl_t         cmp_ctrl;
    cmp_stat_t         cmp_stat;

    sha256he_compress u_compress (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cmp_ctrl),
        .stat  (cmp_stat)
    );

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_acc      = in_valid && !in_stall;
    assign out_valid   = (state_reg == ST_OUT);
    assign out_acc     = out_valid && !out_stall;
    assign digest_word = cmp_stat.rd_data;
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == LAST_INDEX);
    assign block_full  = (word_cnt_reg == LAST_SLOT);

    // Byte merge: clamp the byte count to four, drop unused low bytes,
    // append the new bytes behind the pending ones
    always_comb
    begin
        n_bytes = valid_bytes[2] ? 3'd4 : {1'b0, valid_bytes[1:0]};
        total   = {1'b0, pend_cnt_reg} + n_bytes;
        unique case (n_bytes)
            3'd0:    byte_mask = 32'h0000_0000;
            3'd1:    byte_mask = 32'hff00_0000;
            3'd2:    byte_mask = 32'hffff_0000;
            3'd3:    byte_mask = 32'hffff_ff00;
            default: byte_mask = 32'hffff_ffff;
        endcase
        combined = {pend_reg, 32'h0}
                 | ({data_word & byte_mask, 32'h0} >> {pend_cnt_reg, 3'b000});
    end

    // Padding word: mark byte behind the pending bytes, then zeros, then length
    always_comb
    begin
        priority if (!mark_done_reg)
        begin
            fill_word = pend_reg | (PAD_MARK_WORD >> {pend_cnt_reg, 3'b000});
        end
        else if (len_hi_done_reg)
        begin
            fill_word = bit_cnt_reg[31:0];
        end
        else if (word_cnt_reg == LEN_HI_SLOT)
        begin
            fill_word = bit_cnt_reg[63:32];
        end
        else
        begin
            fill_word = '0;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    priority if (total[2] && block_full)
                    begin
                        state_next = ST_COMP;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_FILL:
            begin
                if (block_full)
                begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                if (cmp_stat.done)
                begin
                    priority if (msg_done_reg)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (eom_reg)
                    begin
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_acc && last_word)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Register updates and commands to the round unit
    always_comb
    begin
        pend_next        = pend_reg;
        pend_cnt_next    = pend_cnt_reg;
        word_cnt_next    = word_cnt_reg;
        bit_cnt_next     = bit_cnt_reg;
        eom_next         = eom_reg;
        mark_done_next   = mark_done_reg;
        len_hi_done_next = len_hi_done_reg;
        msg_done_next    = msg_done_reg;
        idx_next         = idx_reg;

        cmp_ctrl.wr_en      = 1'b0;
        cmp_ctrl.wr_data    = combined[63:32];
        cmp_ctrl.start      = 1'b0;
        cmp_ctrl.chain_init = 1'b0;
        cmp_ctrl.rd_idx     = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    bit_cnt_next  = bit_cnt_reg + {58'h0, n_bytes, 3'b000};
                    eom_next      = end_of_message;
                    pend_cnt_next = total[1:0];
                    if (total[2])
                    begin
                        // Word complete: shift it into the schedule, keep the rest
                        cmp_ctrl.wr_en = 1'b1;
                        cmp_ctrl.start = block_full;
                        pend_next      = combined[31:0];
                        word_cnt_next  = word_cnt_reg + 4'd1;
                    end
                    else
                    begin
                        pend_next = combined[63:32];
                    end
                end
            end
            ST_FILL:
            begin
                cmp_ctrl.wr_en   = 1'b1;
                cmp_ctrl.wr_data = fill_word;
                cmp_ctrl.start   = block_full;
                word_cnt_next    = word_cnt_reg + 4'd1;
                priority if (!mark_done_reg)
                begin
                    mark_done_next = 1'b1;
                    pend_next      = '0;
                    pend_cnt_next  = '0;
                end
                else if (len_hi_done_reg)
                begin
                    msg_done_next = 1'b1;
                end
                else if (word_cnt_reg == LEN_HI_SLOT)
                begin
                    len_hi_done_next = 1'b1;
                end
            end
            ST_COMP:
            begin
                // Hold everything while the round unit runs
            end
            ST_OUT:
            begin
                if (out_acc)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (last_word)
                    begin
                        // Drop the message state, ready for the next one
                        cmp_ctrl.chain_init = 1'b1;
                        bit_cnt_next        = '0;
                        eom_next            = 1'b0;
                        mark_done_next      = 1'b0;
                        len_hi_done_next    = 1'b0;
                        msg_done_next       = 1'b0;
                        pend_next           = '0;
                        pend_cnt_next       = '0;
                        word_cnt_next       = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pend_reg        <= '0;
            pend_cnt_reg    <= '0;
            word_cnt_reg    <= '0;
            bit_cnt_reg     <= '0;
            eom_reg         <= 1'b0;
            mark_done_reg   <= 1'b0;
            len_hi_done_reg <= 1'b0;
            msg_done_reg    <= 1'b0;
            idx_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            pend_reg        <= pend_next;
            pend_cnt_reg    <= pend_cnt_next;
            word_cnt_reg    <= word_cnt_next;
            bit_cnt_reg     <= bit_cnt_next;
            eom_reg         <= eom_next;
            mark_done_reg   <= mark_done_next;
            len_hi_done_reg <= len_hi_done_next;
            msg_done_reg    <= msg_done_next;
            idx_reg         <= idx_next;
        end
    end

endmodule

/* rtl/sha256he_checker.sv */
// ----------------------------------------------------------------------------
// sha256he_checker
// Port-level checks of the SHA-256 engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "sha256_hash_engine_core_assert.svh"

module sha256he_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [31:0] data_word,
    input logic [2:0]  valid_bytes,
    input logic        end_of_message,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);

    `SHA_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(data_word) && $stable(valid_bytes) && $stable(end_of_message), "stalled input item changed")

    `SHA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(digest_word), "stalled digest item changed")

    `SHA_ASSERT_NOW(a_busy_in_out, out_valid, in_stall, "input taken while digest is emitted")

    `SHA_ASSERT_NEXT(a_index_step, out_valid && !out_stall && !last_word, out_valid && (word_index == $past(word_index) + 3'd1), "digest index did not advance")

    `SHA_ASSERT_NEXT(a_last_ends, out_valid && !out_stall && last_word, !out_valid && (word_index == 3'd0), "digest run did not end")

endmodule

bind sha256_hash_engine_core sha256he_checker u_checker (.*);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: SHA-256 streaming engine testbench
// Feeds byte-packed messages, predicts each digest in software and checks
// every digest word in order. Both handshakes pause at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int ITEM_TARGET   = 110;
    localparam int SETTLE_CYCLES = 200;
    localparam int LEN_FIELD_POS = 448;      // bit offset of the length field
    localparam bit [7:0] PAD_BYTE = 8'h80;

    localparam bit [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam bit [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // One message word on its way in; gap is the idle time after it, and
    // drain holds it back until every digest word has come out.
    typedef struct {
        bit [31:0] data;
        bit [2:0]  nbytes;
        bit        eom;
        int        gap;
        bit        drain;
    } msg_item_t;

    typedef struct {
        bit [31:0] word;
        bit [2:0]  idx;
        bit        last;
    } digest_item_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [31:0] data_word      = '0;
    logic [2:0]  valid_bytes    = '0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    msg_item_t    stim_q [$];
    digest_item_t digest_q [$];

    logic in_taken = 1'b0;     // item accepted at the last rising edge
    int   gap_left   = 0;
    int   stall_left = 0;
    int   cycle_count = 0;
    int   err_count   = 0;
    int   words_checked = 0;
    int   items_sent    = 0;   // items that carry bytes or end a message
    int   msg_count     = 0;
    int   max_msg_bytes = 0;
    int   cur_msg_bytes = 0;
    bit   calm = 1'b0;

    // Predictor state: chaining value, 16-word schedule, partial word, length
    bit [31:0] hv [8];
    bit [31:0] wsched [16];
    bit [3:0]  blk_words;
    bit [31:0] part_word;
    bit [1:0]  part_cnt;
    bit [63:0] bit_len;

    sha256_hash_engine_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_word      (data_word),
        .valid_bytes    (valid_bytes),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Digest predictor
    // ------------------------------------------------------------------
    function automatic bit [31:0] rotr(bit [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic clear_hash_state();
        for (int j = 0; j < 8; j++)
        begin
            hv[j] = IV[j];
        end
        blk_words = '0;
        part_word = '0;
        part_cnt  = '0;
        bit_len   = '0;
    endtask

    // Run the 64 rounds over the block in wsched and fold into hv.
    task automatic compress_chunk();
        bit [31:0] v [8];
        bit [31:0] x, y, w, s0, s1, ch, mj, t1, t2;
        for (int j = 0; j < 8; j++)
        begin
            v[j] = hv[j];
        end
        for (int t = 0; t < 64; t++)
        begin
            if (t >= 16)
            begin
                // Extend the schedule in place over the 16-entry window
                x = wsched[(t - 15) & 15];
                y = wsched[(t - 2) & 15];
                wsched[t & 15] = wsched[t & 15]
                               + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3))
                               + wsched[(t - 7) & 15]
                               + (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
            end
            w  = wsched[t & 15];
            s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
            ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1 = v[7] + s1 + ch + KTAB[t] + w;
            s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
            mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2 = s0 + mj;
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++)
        begin
            hv[j] = hv[j] + v[j];
        end
    endtask

    task automatic absorb_byte(bit [7:0] b);
        part_word = {part_word[23:0], b};
        if (part_cnt == 2'd3)
        begin
            wsched[blk_words] = part_word;
            part_word = '0;
            part_cnt  = '0;
            blk_words = blk_words + 4'd1;
            if (blk_words == 4'd0)
                compress_chunk();
        end
        else
        begin
            part_cnt = part_cnt + 2'd1;
        end
    endtask

    // Take one accepted item; on the end of a message pad, append the length
    // and queue the eight digest words.
    task automatic absorb_item(bit [31:0] data, bit [2:0] nb_raw, bit eom);
        int        nb;
        bit [63:0] len;
        nb = (nb_raw > 3'd4) ? 4 : int'(nb_raw);
        for (int k = 0; k < nb; k++)
        begin
            absorb_byte(data[31 - 8 * k -: 8]);
            bit_len = bit_len + 64'd8;
        end
        if (eom)
        begin
            len = bit_len;
            absorb_byte(PAD_BYTE);
            while (int'(blk_words) * 32 + int'(part_cnt) * 8 != LEN_FIELD_POS)
                absorb_byte(8'h00);
            for (int s = 56; s >= 0; s -= 8)
                absorb_byte(len[s +: 8]);
            for (int k = 0; k < 8; k++)
                digest_q.push_back('{word: hv[k], idx: k[2:0], last: (k == 7)});
            clear_hash_state();
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        if (calm)
            return 0;
        case ($urandom_range(0, 19))
            0:       return $urandom_range(20, 60);
            1, 2, 3,
            4, 5:    return $urandom_range(1, 3);
            default: return 0;
        endcase
    endfunction

    task automatic push_item(bit [31:0] data, bit [2:0] nb, bit eom, bit drain);
        stim_q.push_back('{data: data, nbytes: nb, eom: eom, gap: pick_gap(),
                           drain: drain});
        if (nb != 3'd0 || eom)
            items_sent++;
        cur_msg_bytes += (nb > 3'd4) ? 4 : int'(nb);
        if (eom)
        begin
            msg_count++;
            if (cur_msg_bytes > max_msg_bytes)
                max_msg_bytes = cur_msg_bytes;
            cur_msg_bytes = 0;
        end
    endtask

    // Build one random message; a noisy one mixes in partial and empty items.
    task automatic add_message(bit noisy, bit drain_first);
        int       nwords;
        bit [2:0] nb;
        nwords = ($urandom_range(0, 6) == 0) ? $urandom_range(26, 36)
                                             : $urandom_range(0, 16);
        for (int n = 0; n < nwords; n++)
        begin
            if (noisy && $urandom_range(0, 2) == 0)
                nb = 3'($urandom_range(0, 7));
            else if ($urandom_range(0, 9) == 0)
                nb = 3'($urandom_range(5, 7));
            else
                nb = 3'd4;
            push_item($urandom, nb, 1'b0, drain_first && n == 0);
        end
        nb = noisy ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 4));
        push_item($urandom, nb, 1'b1, drain_first && nwords == 0);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, bit [31:0] got, bit [31:0] want);
        $display("tb: MISMATCH %s: got %h, expected %h (cycle %0d)",
                 what, got, want, cycle_count);
        err_count++;
    endtask

    // Sample both handshakes at the rising edge: predict on an accepted item,
    // check on an accepted digest word.
    always @(posedge clk)
    begin
        digest_item_t want;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                absorb_item(data_word, valid_bytes, end_of_message);
            if (out_valid && !out_stall)
            begin
                if (digest_q.size() == 0)
                begin
                    report_mismatch("digest word with none expected", digest_word, '0);
                end
                else
                begin
                    want = digest_q.pop_front();
                    words_checked++;
                    if (digest_word !== want.word)
                        report_mismatch("digest_word", digest_word, want.word);
                    if (word_index !== want.idx)
                        report_mismatch("word_index", 32'(word_index), 32'(want.idx));
                    if (last_word !== want.last)
                        report_mismatch("last_word", 32'(last_word), 32'(want.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: advance to the next item only once the current one is taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        msg_item_t it;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (stim_q.size() != 0 && !(stim_q[0].drain && digest_q.size() != 0))
            begin
                it = stim_q.pop_front();
                data_word      <= it.data;
                valid_bytes    <= it.nbytes;
                end_of_message <= it.eom;
                in_valid       <= 1'b1;
                gap_left = it.gap;
            end
            else
            begin
                // Hold off: queue empty, or waiting for the digest to drain
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure; no new stall starts in windows whose index is a multiple of four.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if ((cycle_count / 2048) % 4 != 0 && $urandom_range(0, 3) == 0)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 3);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed messages, random messages, drain, verdict
    // ------------------------------------------------------------------
    initial
    begin
        clear_hash_state();

        // Empty message: single empty ending item
        push_item($urandom, 3'd0, 1'b1, 1'b0);
        // Three-byte message; junk in the unused low byte must be dropped
        push_item({24'h616263, 8'($urandom)}, 3'd3, 1'b1, 1'b0);
        // Partial item mid-message, empty non-ending item, oversized counts
        push_item($urandom, 3'd2, 1'b0, 1'b0);
        push_item($urandom, 3'd0, 1'b0, 1'b0);
        push_item($urandom, 3'd7, 1'b0, 1'b0);
        push_item($urandom, 3'd1, 1'b0, 1'b0);
        push_item($urandom, 3'd5, 1'b0, 1'b0);
        push_item($urandom, 3'd4, 1'b1, 1'b0);
        // 56 bytes of all-zero / all-one words: the padding spills into a
        // second block; the ending item is empty
        for (int n = 0; n < 14; n++)
            push_item((n % 2 == 0) ? 32'hffff_ffff : 32'h0000_0000, 3'd4, 1'b0, 1'b0);
        push_item($urandom, 3'd0, 1'b1, 1'b0);

        // Random messages; the first one waits for the directed digests
        for (int m = 0; items_sent < ITEM_TARGET; m++)
        begin
            calm = ($urandom_range(0, 4) == 0);
            add_message($urandom_range(0, 3) == 0, m == 0 || $urandom_range(0, 7) == 0);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || in_valid || digest_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("tb: %0d messages from %0d items, longest %0d bytes",
                 msg_count, items_sent, max_msg_bytes);
        $display("tb: %0d digest words checked, %0d mismatches",
                 words_checked, err_count);
        if (err_count == 0 && digest_q.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

/* sha256_hash_engine_core.f */
+incdir+rtl
rtl/sha256he_pkg.sv
rtl/sha256he_compress.sv
rtl/sha256_hash_engine_core.sv
rtl/sha256he_checker.sv
test/tb.sv
